@@ rtl/prefixed_integer_literal_parser_assert.svh @@
// assertion macros used by the parser top level
`ifndef PREFIXED_INTEGER_LITERAL_PARSER_ASSERT_SVH
`define PREFIXED_INTEGER_LITERAL_PARSER_ASSERT_SVH

// same-cycle implication, checked on every rising edge out of reset
`define PILP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PILP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pilp_pkg.sv @@
// shared types and constants of the prefixed integer literal parser
package pilp_pkg;

    // base codes as reported on the result
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_HEX = 2'd2;

    // ascii codes the parser looks for
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_SEVEN   = 8'h37;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_X = 8'h78;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    // marks a character that is not a digit of the current base
    localparam logic [4:0] DIGIT_NONE = 5'd16;

    // one character beat
    typedef struct packed {
        logic [7:0] char_code;
        logic       word_end;
    } pilp_in_t;

    // one result beat
    typedef struct packed {
        logic signed [31:0] parsed_value;
        logic [1:0]         base_code;
        logic               parse_ok;
    } pilp_out_t;

endpackage

@@ rtl/pilp_core.sv @@
// parser state and the per-character update of sign, base and magnitude
module pilp_core
    import pilp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  pilp_in_t  beat,
    output pilp_out_t res
);

    typedef enum logic [2:0] {
        PH_START,
        PH_BASE,
        PH_ZERO,
        PH_SIGN,
        PH_DIGITS
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        outer_minus_reg, outer_minus_next;
    logic        inner_minus_reg, inner_minus_next;
    logic [1:0]  radix_reg, radix_next;
    logic [31:0] mag_reg, mag_next;
    logic        seen_reg, seen_next;
    logic        done_reg, done_next;
    logic        ovf_reg, ovf_next;

    // digit value of a character in the given base, DIGIT_NONE if none
    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic [1:0] rs);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = 5'(c - CH_ZERO);
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            d = 5'(c - CH_LOWER_A + 8'd10);
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            d = 5'(c - CH_UPPER_A + 8'd10);
        if (rs == RADIX_OCT && d >= 5'd8)
            d = DIGIT_NONE;
        if (rs == RADIX_DEC && d >= 5'd10)
            d = DIGIT_NONE;
        return d;
    endfunction

    logic        pass;
    logic [4:0]  digit;
    logic [35:0] mag_wide;
    logic [35:0] product;
    logic [35:0] sum;
    logic [35:0] limit;
    logic        ok;
    logic [31:0] value;

    // walk the phases for one character; a consumed character stops the walk
    always_comb
    begin
        phase_next       = phase_reg;
        outer_minus_next = outer_minus_reg;
        inner_minus_next = inner_minus_reg;
        radix_next       = radix_reg;
        mag_next         = mag_reg;
        seen_next        = seen_reg;
        done_next        = done_reg;
        ovf_next         = ovf_reg;
        pass             = 1'b1;
        digit            = DIGIT_NONE;
        mag_wide         = {4'd0, mag_reg};
        product          = '0;
        sum              = '0;
        limit            = '0;

        if (phase_next == PH_START)
        begin
            if (beat.char_code == CH_MINUS)
            begin
                outer_minus_next = 1'b1;
                pass             = 1'b0;
            end
            phase_next = PH_BASE;
        end

        if (pass && phase_next == PH_BASE)
        begin
            if (beat.char_code == CH_ZERO)
            begin
                phase_next = PH_ZERO;
                pass       = 1'b0;
            end
            else
                phase_next = PH_SIGN;
        end

        // leading zero: hex prefix, octal prefix or a plain decimal zero
        if (pass && phase_next == PH_ZERO)
        begin
            if (beat.char_code == CH_LOWER_X)
            begin
                radix_next = RADIX_HEX;
                phase_next = PH_SIGN;
                pass       = 1'b0;
            end
            else
            begin
                if (beat.char_code >= CH_ZERO && beat.char_code <= CH_SEVEN)
                    radix_next = RADIX_OCT;
                else
                    seen_next = 1'b1;
                phase_next = PH_DIGITS;
            end
        end

        if (pass && phase_next == PH_SIGN)
        begin
            if (beat.char_code == CH_PLUS)
                pass = 1'b0;
            else if (beat.char_code == CH_MINUS)
            begin
                inner_minus_next = 1'b1;
                pass             = 1'b0;
            end
            phase_next = PH_DIGITS;
        end

        // digit accumulation: magnitude * base + digit with limit check
        if (pass && phase_next == PH_DIGITS && !done_next)
        begin
            digit = digit_of(beat.char_code, radix_next);
            unique case (radix_next)
                RADIX_HEX: product = mag_wide << 4;
                RADIX_OCT: product = mag_wide << 3;
                default:   product = (mag_wide << 3) + (mag_wide << 1);
            endcase
            sum   = product + 36'(digit[3:0]);
            limit = inner_minus_next ? 36'h0_8000_0000 : 36'h0_7FFF_FFFF;
            if (digit == DIGIT_NONE)
                done_next = 1'b1;
            else
            begin
                seen_next = 1'b1;
                if (!ovf_next)
                begin
                    if (sum > limit)
                        ovf_next = 1'b1;
                    else
                        mag_next = sum[31:0];
                end
            end
        end

        // a word that ends right after its leading zero holds the digit zero
        if (beat.word_end && phase_next == PH_ZERO)
            seen_next = 1'b1;
    end

    // result of a closing character
    always_comb
    begin
        ok    = seen_next && !ovf_next;
        value = (inner_minus_next ^ outer_minus_next) ? (32'd0 - mag_next) : mag_next;
        res.parsed_value = ok ? value : 32'd0;
        res.base_code    = radix_next;
        res.parse_ok     = ok;
    end

    // parser state, back to start of word after each closing character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_START;
            outer_minus_reg <= 1'b0;
            inner_minus_reg <= 1'b0;
            radix_reg       <= RADIX_DEC;
            mag_reg         <= 32'd0;
            seen_reg        <= 1'b0;
            done_reg        <= 1'b0;
            ovf_reg         <= 1'b0;
        end
        else if (step)
        begin
            if (beat.word_end)
            begin
                phase_reg       <= PH_START;
                outer_minus_reg <= 1'b0;
                inner_minus_reg <= 1'b0;
                radix_reg       <= RADIX_DEC;
                mag_reg         <= 32'd0;
                seen_reg        <= 1'b0;
                done_reg        <= 1'b0;
                ovf_reg         <= 1'b0;
            end
            else
            begin
                phase_reg       <= phase_next;
                outer_minus_reg <= outer_minus_next;
                inner_minus_reg <= inner_minus_next;
                radix_reg       <= radix_next;
                mag_reg         <= mag_next;
                seen_reg        <= seen_next;
                done_reg        <= done_next;
                ovf_reg         <= ovf_next;
            end
        end
    end

endmodule

@@ rtl/prefixed_integer_literal_parser.sv @@
// top level of the prefixed integer literal parser: beat registers and handshake
//
//   channel  | direction | payload    | handshake
//   char     | in        | pilp_in_t  | char_valid / char_stall
//   result   | out       | pilp_out_t | result_valid / result_stall
//
// one character per cycle while char_stall is low, set by the combinational update in pilp_core
// a result passes from its closing character through the input register, then the result register
// reset clears both beat valids and the parser state, payload registers are left as they are
// a character without word_end moves on even while a result is stalled
// a closing character waits in the input register while the result register is full and stalled
module prefixed_integer_literal_parser
    import pilp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      char_valid,
    output logic      char_stall,
    input  pilp_in_t  char_beat,
    output logic      result_valid,
    input  logic      result_stall,
    output pilp_out_t result_beat
);

    `include "prefixed_integer_literal_parser_assert.svh"

    logic      char_vld_reg, char_vld_next;
    pilp_in_t  char_reg;
    logic      res_vld_reg, res_vld_next;
    pilp_out_t res_reg;
    pilp_out_t core_res;
    logic      res_free;
    logic      step;
    logic      take;

    // the held character goes through unless it closes a word and the result is blocked
    assign res_free   = !res_vld_reg || !result_stall;
    assign step       = char_vld_reg && (!char_reg.word_end || res_free);
    assign char_stall = char_vld_reg && !step;
    assign take       = char_valid && !char_stall;

    pilp_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .beat  (char_reg),
        .res   (core_res)
    );

    // valid bits of the two beat registers
    always_comb
    begin
        char_vld_next = char_vld_reg;
        if (take)
            char_vld_next = 1'b1;
        else if (step)
            char_vld_next = 1'b0;

        res_vld_next = res_vld_reg;
        if (step && char_reg.word_end)
            res_vld_next = 1'b1;
        else if (!result_stall)
            res_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            char_vld_reg <= char_vld_next;
            res_vld_reg  <= res_vld_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
            char_reg <= char_beat;
        if (step && char_reg.word_end)
            res_reg <= core_res;
    end

    assign result_valid = res_vld_reg;
    assign result_beat  = res_reg;

    `PILP_ASSERT_NOW(a_no_overwrite, res_vld_reg && result_stall, !(step && char_reg.word_end),
        "waiting result overwritten")
    `PILP_ASSERT_NOW(a_invalid_is_zero, res_vld_reg && !res_reg.parse_ok,
        res_reg.parsed_value == 32'd0, "invalid result carries a nonzero value")
    `PILP_ASSERT_NOW(a_base_known, res_vld_reg, res_reg.base_code != 2'b11,
        "unknown base code on result")
    `PILP_ASSERT_NEXT(a_end_gives_result, step && char_reg.word_end, res_vld_reg,
        "closing character gave no result")

endmodule

@@ dv/tb.sv @@
// self-checking testbench for the prefixed integer literal parser
`timescale 1ns / 1ps

module tb;
    import pilp_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int HOLD_CYCLES   = 250;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;

    // where the parser stands within the current word
    typedef enum logic [2:0] {
        WP_START,
        WP_BASE,
        WP_ZERO,
        WP_SIGN,
        WP_DIGITS
    } word_phase_t;

    logic      clk;
    logic      rst_n;
    logic      char_valid;
    logic      char_stall;
    pilp_in_t  char_beat;
    logic      result_valid;
    logic      result_stall;
    pilp_out_t result_beat;

    // mirrored parser state
    word_phase_t wp_phase;
    logic        wp_outer_minus;
    logic        wp_inner_minus;
    logic [1:0]  wp_radix;
    logic [31:0] wp_magnitude;
    logic        wp_digit_seen;
    logic        wp_digits_done;
    logic        wp_overflow;

    pilp_out_t   due_results[$];
    logic [7:0]  word_chars[$];
    int          error_count;
    int          sent_items;
    int          idle_cycles;
    bit          no_idle;
    int          holds_asked;
    int          holds_given;

    prefixed_integer_literal_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .char_beat    (char_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_beat  (result_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // value of a character as a digit of the given base
    function automatic logic [4:0] digit_of(logic [7:0] c, logic [1:0] radix);
        logic [4:0] d;
        d = DIGIT_NONE;
        if (c >= CH_ZERO && c <= CH_NINE)
            d = 5'(c - CH_ZERO);
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            d = 5'(c - CH_LOWER_A + 8'd10);
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            d = 5'(c - CH_UPPER_A + 8'd10);
        if (radix == RADIX_OCT && d >= 5'd8)
            d = DIGIT_NONE;
        if (radix == RADIX_DEC && d >= 5'd10)
            d = DIGIT_NONE;
        return d;
    endfunction

    task automatic clear_word();
        wp_phase       = WP_START;
        wp_outer_minus = 1'b0;
        wp_inner_minus = 1'b0;
        wp_radix       = RADIX_DEC;
        wp_magnitude   = 32'd0;
        wp_digit_seen  = 1'b0;
        wp_digits_done = 1'b0;
        wp_overflow    = 1'b0;
    endtask

    // append one character to the word being built
    task automatic add_char(logic [7:0] c);
        word_chars.insert(word_chars.size(), c);
    endtask

    // multiply-add one digit, the magnitude freezes once it overflows
    task automatic take_digit(logic [4:0] d);
        logic [63:0] next_mag;
        logic [63:0] lim;
        next_mag = {32'd0, wp_magnitude} * ((wp_radix == RADIX_HEX) ? 64'd16 :
                   (wp_radix == RADIX_OCT) ? 64'd8 : 64'd10) + 64'(d);
        lim = wp_inner_minus ? 64'h8000_0000 : 64'h7FFF_FFFF;
        wp_digit_seen = 1'b1;
        if (!wp_overflow)
        begin
            if (next_mag > lim)
                wp_overflow = 1'b1;
            else
                wp_magnitude = next_mag[31:0];
        end
    endtask

    // advance the mirrored parser by one accepted character beat
    task automatic track_char(pilp_in_t b);
        logic       pass;
        logic [4:0] d;
        logic [31:0] v;
        logic       ok;
        pilp_out_t  res;
        pass = 1'b1;
        if (wp_phase == WP_START)
        begin
            if (b.char_code == CH_MINUS)
            begin
                wp_outer_minus = 1'b1;
                pass = 1'b0;
            end
            wp_phase = WP_BASE;
        end
        if (pass && wp_phase == WP_BASE)
        begin
            if (b.char_code == CH_ZERO)
            begin
                wp_phase = WP_ZERO;
                pass = 1'b0;
            end
            else
                wp_phase = WP_SIGN;
        end
        if (pass && wp_phase == WP_ZERO)
        begin
            if (b.char_code == CH_LOWER_X)
            begin
                wp_radix = RADIX_HEX;
                wp_phase = WP_SIGN;
                pass = 1'b0;
            end
            else
            begin
                if (b.char_code >= CH_ZERO && b.char_code <= CH_SEVEN)
                    wp_radix = RADIX_OCT;
                else
                    take_digit(5'd0);
                wp_phase = WP_DIGITS;
            end
        end
        if (pass && wp_phase == WP_SIGN)
        begin
            if (b.char_code == CH_PLUS)
                pass = 1'b0;
            else if (b.char_code == CH_MINUS)
            begin
                wp_inner_minus = 1'b1;
                pass = 1'b0;
            end
            wp_phase = WP_DIGITS;
        end
        if (pass && wp_phase == WP_DIGITS && !wp_digits_done)
        begin
            d = digit_of(b.char_code, wp_radix);
            if (d == DIGIT_NONE)
                wp_digits_done = 1'b1;
            else
                take_digit(d);
        end

        // closing character: a pending zero counts as a digit, then emit
        if (b.word_end)
        begin
            if (wp_phase == WP_ZERO)
                take_digit(5'd0);
            ok = wp_digit_seen && !wp_overflow;
            v = 32'd0;
            if (ok)
            begin
                v = wp_inner_minus ? 32'd0 - wp_magnitude : wp_magnitude;
                if (wp_outer_minus)
                    v = 32'd0 - v;
            end
            res.parsed_value = v;
            res.base_code    = wp_radix;
            res.parse_ok     = ok;
            due_results.insert(due_results.size(), res);
            clear_word();
        end
    endtask

    // mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // offer one character beat and wait until it is taken
    task automatic send_char(logic [7:0] c, logic last);
        int       gap;
        pilp_in_t b;
        gap = pick_gap();
        if (gap > 0)
        begin
            char_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        b.char_code = c;
        b.word_end  = last;
        char_valid <= 1'b1;
        char_beat  <= b;
        do
            @(posedge clk);
        while (char_stall);
        track_char(b);
        sent_items++;
    endtask

    task automatic send_word();
        int n;
        n = word_chars.size();
        for (int i = 0; i < n; i++)
            send_char(word_chars[i], i == n - 1);
        word_chars.delete();
    endtask

    task automatic send_text(string s);
        foreach (s[i])
            add_char(s[i]);
        send_word();
    endtask

    // digits of a magnitude in the given base, hex letters in random case
    task automatic append_number(logic [39:0] mag, logic [1:0] radix);
        logic [39:0] weight;
        logic [39:0] rest;
        logic [7:0]  digs[$];
        logic [7:0]  dv;
        weight = (radix == RADIX_HEX) ? 40'd16 : (radix == RADIX_OCT) ? 40'd8 : 40'd10;
        rest = mag;
        do
        begin
            dv = 8'(rest % weight);
            rest = rest / weight;
            if (dv < 8'd10)
                digs.push_front(CH_ZERO + dv);
            else if ($urandom_range(0, 1))
                digs.push_front(CH_LOWER_A + dv - 8'd10);
            else
                digs.push_front(CH_UPPER_A + dv - 8'd10);
        end
        while (rest != 0);
        foreach (digs[i])
            add_char(digs[i]);
    endtask

    // small values, full range, the signed limits and values past 32 bits
    function automatic logic [39:0] pick_magnitude();
        case ($urandom_range(0, 6))
            0, 1:    return 40'($urandom_range(0, 99));
            2:       return 40'($urandom);
            3, 4:    return 40'h8000_0000 + 40'($urandom_range(0, 2)) - 40'd1;
            5:       return {8'($urandom), 32'($urandom)};
            default: return 40'($urandom_range(0, 65535));
        endcase
    endfunction

    // well-formed literal: signs, prefix, digits and sometimes trailing junk
    task automatic build_literal();
        int         r;
        logic [1:0] radix;
        if ($urandom_range(0, 1))
            add_char(CH_MINUS);
        r = $urandom_range(0, 2);
        radix = (r == 0) ? RADIX_DEC : (r == 1) ? RADIX_OCT : RADIX_HEX;
        if (radix != RADIX_DEC)
            add_char(CH_ZERO);
        if (radix == RADIX_HEX)
            add_char(CH_LOWER_X);
        case ($urandom_range(0, 3))
            0:       add_char(CH_PLUS);
            1:       add_char(CH_MINUS);
            default: ;
        endcase
        append_number(pick_magnitude(), radix);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3))
                add_char(8'($urandom));
    endtask

    // short word of random bytes and characters the parser reacts to
    task automatic build_noise();
        string alphabet;
        alphabet = "0x+-789aFG";
        repeat ($urandom_range(1, 8))
        begin
            if ($urandom_range(0, 1))
                add_char(8'($urandom));
            else
                add_char(alphabet[$urandom_range(0, alphabet.len() - 1)]);
        end
    endtask

    task automatic send_random_words(int count);
        int start;
        start = sent_items;
        while (sent_items - start < count)
        begin
            if ($urandom_range(0, 3) != 0)
                build_literal();
            else
                build_noise();
            send_word();
        end
    endtask

    // sender goes quiet until every pending result is out
    task automatic wait_results_drained();
        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
    endtask

    task automatic test_directed();
        send_text("0");             // lone zero closing the word
        send_text("08");            // zero then a non-octal digit stays decimal
        send_text("07");            // octal prefix
        send_text("-0xaF");         // hex letters in both cases, outer minus
        send_text("+");             // no digits at all
        send_text("0x");            // hex prefix without digits
        send_text("--5");           // outer and inner minus cancel
        send_text("-0x-80000000");  // most negative magnitude negated twice wraps
        add_char(8'h00);
        add_char(8'hFF);
        send_word();                // extreme character codes
    endtask

    task automatic test_random_words();
        send_random_words(700);
    endtask

    task automatic test_no_idle();
        no_idle = 1'b1;
        send_random_words(150);
        no_idle = 1'b0;
    endtask

    // receiver holds off long enough for the parser to back up
    task automatic test_result_hold();
        holds_asked++;
        send_random_words(150);
    endtask

    task automatic test_sender_pause();
        send_random_words(80);
        wait_results_drained();
        send_random_words(80);
    endtask

    // result side: random stall bursts, or one long hold on request
    initial
    begin : result_side
        int n;
        result_stall = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (holds_given != holds_asked)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_given++;
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            result_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // compare each accepted result beat with the oldest pending word
    always @(posedge clk)
    begin : check_results
        pilp_out_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (due_results.size() == 0)
            begin
                $error("result beat with no word pending");
                error_count++;
            end
            else
            begin
                want = due_results.pop_front();
                if (result_beat.parsed_value !== want.parsed_value)
                begin
                    $error("parsed_value: expected %0d, got %0d",
                           want.parsed_value, result_beat.parsed_value);
                    error_count++;
                end
                if (result_beat.base_code !== want.base_code)
                begin
                    $error("base_code: expected %0d, got %0d",
                           want.base_code, result_beat.base_code);
                    error_count++;
                end
                if (result_beat.parse_ok !== want.parse_ok)
                begin
                    $error("parse_ok: expected %0b, got %0b",
                           want.parse_ok, result_beat.parse_ok);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if (!rst_n || (char_valid && !char_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n        = 1'b0;
        char_valid   = 1'b0;
        char_beat    = '0;
        sent_items   = 0;
        no_idle      = 1'b0;
        clear_word();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_words();
        test_no_idle();
        test_result_hold();
        test_sender_pause();

        // drain, then let the pipeline settle
        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (due_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0 && due_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
